[hdl/kslp_pkg.sv]
package kslp_pkg;

  localparam int NUM_KEYS  = 8;
  localparam int KEY_IDX_W = 3;
  localparam int TICKS_W   = 16;
  localparam int CODE_W    = 4;

  // Key positions in key_pressed
  localparam logic [KEY_IDX_W-1:0] KEY_POWER  = 3'd0;
  localparam logic [KEY_IDX_W-1:0] KEY_MODE   = 3'd1;
  localparam logic [KEY_IDX_W-1:0] KEY_DOWN   = 3'd2;
  localparam logic [KEY_IDX_W-1:0] KEY_UP     = 3'd3;
  localparam logic [KEY_IDX_W-1:0] KEY_PLASMA = 3'd4;
  localparam logic [KEY_IDX_W-1:0] KEY_DRY    = 3'd5;
  localparam logic [KEY_IDX_W-1:0] KEY_MOUSE  = 3'd6;
  localparam logic [KEY_IDX_W-1:0] KEY_WIFI   = 3'd7;

  localparam logic [TICKS_W-1:0] LONG_PRESS_RESET = 16'd40;

  typedef logic [CODE_W-1:0] event_code_t;

  localparam event_code_t EV_POWER_SHORT  = 4'd0;
  localparam event_code_t EV_POWER_LONG   = 4'd1;
  localparam event_code_t EV_MODE_SHORT   = 4'd2;
  localparam event_code_t EV_MODE_LONG    = 4'd3;
  localparam event_code_t EV_DOWN_SHORT   = 4'd4;
  localparam event_code_t EV_UP_SHORT     = 4'd5;
  localparam event_code_t EV_PLASMA_SHORT = 4'd6;
  localparam event_code_t EV_DRY_SHORT    = 4'd7;
  localparam event_code_t EV_MOUSE_SHORT  = 4'd8;
  localparam event_code_t EV_WIFI_LONG    = 4'd9;

  typedef struct packed {
    logic        valid;
    event_code_t code;
  } key_event_t;

  // Key has a short event on release
  function automatic logic has_short(input logic [KEY_IDX_W-1:0] k);
    return k != KEY_WIFI;
  endfunction

  // Key has a long event at threshold
  function automatic logic has_long(input logic [KEY_IDX_W-1:0] k);
    return (k == KEY_POWER) || (k == KEY_MODE) || (k == KEY_WIFI);
  endfunction

  function automatic event_code_t short_code(input logic [KEY_IDX_W-1:0] k);
    event_code_t c;
    unique case (k)
      KEY_POWER:  c = EV_POWER_SHORT;
      KEY_MODE:   c = EV_MODE_SHORT;
      KEY_DOWN:   c = EV_DOWN_SHORT;
      KEY_UP:     c = EV_UP_SHORT;
      KEY_PLASMA: c = EV_PLASMA_SHORT;
      KEY_DRY:    c = EV_DRY_SHORT;
      KEY_MOUSE:  c = EV_MOUSE_SHORT;
      default:    c = EV_POWER_SHORT;  // wifi: gated off by has_short
    endcase
    return c;
  endfunction

  function automatic event_code_t long_code(input logic [KEY_IDX_W-1:0] k);
    event_code_t c;
    unique case (k)
      KEY_POWER: c = EV_POWER_LONG;
      KEY_MODE:  c = EV_MODE_LONG;
      KEY_WIFI:  c = EV_WIFI_LONG;
      default:   c = EV_POWER_SHORT;  // gated off by has_long
    endcase
    return c;
  endfunction

endpackage

[hdl/kslp_scan.sv]
module kslp_scan #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic [kslp_pkg::NUM_KEYS-1:0][COUNT_WIDTH-1:0] counts,
  input  logic [kslp_pkg::NUM_KEYS-1:0]                  key_pressed,
  input  logic                                           powered,
  input  logic [kslp_pkg::TICKS_W-1:0]                   long_press_ticks,
  output logic [kslp_pkg::NUM_KEYS-1:0][COUNT_WIDTH-1:0] counts_next,
  output kslp_pkg::key_event_t                           evt
);

  // Compare width covers both the counter and the threshold
  localparam int CMP_W = (COUNT_WIDTH > kslp_pkg::TICKS_W) ? COUNT_WIDTH : kslp_pkg::TICKS_W;

  logic [kslp_pkg::NUM_KEYS-1:0] press;
  logic [kslp_pkg::NUM_KEYS-1:0] release_hit;
  logic [kslp_pkg::NUM_KEYS-1:0] sel;
  logic [kslp_pkg::NUM_KEYS-1:0] sat;
  logic [kslp_pkg::NUM_KEYS-1:0] ev_hit;
  kslp_pkg::event_code_t         ev_code [kslp_pkg::NUM_KEYS];
  logic [CMP_W-1:0]              ticks_ext;

  assign ticks_ext = CMP_W'(long_press_ticks);

  // Per-key press / release tests and candidate events
  always_comb begin
    for (int k = 0; k < kslp_pkg::NUM_KEYS; k++) begin
      logic [CMP_W-1:0]                 c_ext;
      logic [kslp_pkg::KEY_IDX_W-1:0]   kid;
      kid            = kslp_pkg::KEY_IDX_W'(k);
      c_ext          = CMP_W'(counts[k]);
      press[k]       = key_pressed[k] && ((kid == kslp_pkg::KEY_POWER) || powered);
      release_hit[k] = (counts[k] != '0) && !key_pressed[k];
      sat[k]         = (counts[k] == '1);
      if (press[k]) begin
        ev_hit[k]  = !sat[k] && ((c_ext + CMP_W'(1)) == ticks_ext)
                     && kslp_pkg::has_long(kid) && powered;
        ev_code[k] = kslp_pkg::long_code(kid);
      end else begin
        ev_hit[k]  = (c_ext < ticks_ext) && kslp_pkg::has_short(kid);
        ev_code[k] = kslp_pkg::short_code(kid);
      end
    end
  end

  // First matching key in priority order wins
  always_comb begin
    logic found;
    found = 1'b0;
    for (int k = 0; k < kslp_pkg::NUM_KEYS; k++) begin
      sel[k] = !found && (press[k] || release_hit[k]);
      found  = found || press[k] || release_hit[k];
    end
  end

  // Counter update for the selected key only
  always_comb begin
    for (int k = 0; k < kslp_pkg::NUM_KEYS; k++) begin
      counts_next[k] = counts[k];
      if (sel[k]) begin
        if (press[k]) begin
          if (!sat[k]) counts_next[k] = counts[k] + COUNT_WIDTH'(1);
        end else begin
          counts_next[k] = '0;
        end
      end
    end
  end

  // Event mux; code reads zero when no event
  always_comb begin
    evt = '0;
    for (int k = 0; k < kslp_pkg::NUM_KEYS; k++) begin
      if (sel[k] && ev_hit[k]) begin
        evt.valid = 1'b1;
        evt.code  = evt.code | ev_code[k];
      end
    end
  end

endmodule

[hdl/key_short_long_press_detector.sv]
// Key short/long press detector. One scan tick (eight key levels on s_axis_tdata, the
// power-on flag on s_axis_tuser) is taken per clock unless stalled and yields exactly one
// result; the tick is held in the input register, its result in the result register:
// event_valid on m_axis_tuser, the event code on m_axis_tdata (zero when no event).
// Sustained rate is one tick per cycle when not stalled, set by the per-key counter
// read-modify-write, which finishes between the input register and the result register.
// While m_axis_tready is low the result register holds, then the input register fills
// and s_axis_tready drops. The long-press threshold is written through the cfg channel
// (reset value 40) only while no tick is in flight; the user ensures this, not the block.
module key_short_long_press_detector #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,       // long_press_ticks
  // Tick input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_pressed
  input  logic [0:0]  s_axis_tuser,   // [0] powered
  // Event output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] event_code, [7:4] zero
  output logic [0:0]  m_axis_tuser    // [0] event_valid
);

  logic [kslp_pkg::TICKS_W-1:0]                   long_press_ticks;
  logic                                           s1_valid;
  logic [kslp_pkg::NUM_KEYS-1:0]                  s1_keys;
  logic                                           s1_pwr;
  logic [kslp_pkg::NUM_KEYS-1:0][COUNT_WIDTH-1:0] counts;
  logic [kslp_pkg::NUM_KEYS-1:0][COUNT_WIDTH-1:0] counts_next;
  kslp_pkg::key_event_t                           evt;
  logic                                           out_valid;
  kslp_pkg::key_event_t                           out_evt;
  logic                                           in_fire;
  logic                                           out_free;
  logic                                           s1_fire;
  logic [kslp_pkg::NUM_KEYS-1:0]                  change;

  // Handshake
  assign out_free      = !out_valid || m_axis_tready;
  assign s1_fire       = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= kslp_pkg::LONG_PRESS_RESET;
    end else if (cfg_valid) begin
      long_press_ticks <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_keys <= s_axis_tdata;
      s1_pwr  <= s_axis_tuser[0];
    end
  end

  kslp_scan #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_scan (
    .counts          (counts),
    .key_pressed     (s1_keys),
    .powered         (s1_pwr),
    .long_press_ticks(long_press_ticks),
    .counts_next     (counts_next),
    .evt             (evt)
  );

  // Press counters
  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
    end else if (s1_fire) begin
      counts <= counts_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_evt <= evt;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_evt.code};
  assign m_axis_tuser  = out_evt.valid;

  // Keys whose counter moves this cycle
  always_comb begin
    for (int k = 0; k < kslp_pkg::NUM_KEYS; k++) begin
      change[k] = counts_next[k] != counts[k];
    end
  end

  // At most one counter changes per tick
  assert property (@(posedge clk) disable iff (rst) s1_fire |-> $onehot0(change))
    else $error("more than one press counter updated in one tick");

  // Counters hold when no tick is processed
  assert property (@(posedge clk) disable iff (rst) !s1_fire |=> $stable(counts))
    else $error("press counters changed without a tick");

  // A processed tick always lands in the result register
  assert property (@(posedge clk) disable iff (rst) s1_fire |=> out_valid)
    else $error("processed tick produced no result");

  // Empty input stage must take a new tick
  assert property (@(posedge clk) disable iff (rst) !s1_valid |-> s_axis_tready)
    else $error("input stalled while input stage empty");

  // No event means a zero code
  assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_evt.valid |-> out_evt.code == kslp_pkg::EV_POWER_SHORT)
    else $error("nonzero event code without event");

endmodule
